[rtl/ftc_pkg.sv]
// Shared package for the flow table traffic counter.
// Holds protocol constants, the flow key and link types, counter types and
// the saturating arithmetic helpers. No dependencies.
`default_nettype none

package ftc_pkg;

  // Default flow table depth
  localparam int unsigned FLOW_ENTRIES_DEF = 64;

  // Protocol and ether type codes
  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [15:0] L2_TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] L2_TYPE_IPV6 = 16'h86DD;

  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_PEND
  } ftc_state_t;

  // Five-tuple key, as stored in each table cell
  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_l4;
    logic [15:0] dst_l4;
    logic [7:0]  protocol;
  } ftc_key_t;

  // Lookup token handed from cell to cell
  typedef struct packed {
    logic tok;
    logic hit;
  } ftc_link_t;

  // Running counters
  typedef struct packed {
    logic [31:0] flows_total;
    logic [31:0] flows_tcp;
    logic [31:0] flows_udp;
    logic [31:0] packets_total;
    logic [31:0] packets_tcp;
    logic [31:0] packets_udp;
    logic [31:0] bytes_tcp;
    logic [31:0] bytes_udp;
  } ftc_counts_t;

  // Saturating increment
  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == CNT_MAX) ? v : v + 32'd1;
  endfunction

  // Saturating add of a frame length
  function automatic logic [31:0] sat_add(input logic [31:0] v, input logic [15:0] a);
    logic [32:0] s;
    s = {1'b0, v} + {17'b0, a};
    return s[32] ? CNT_MAX : s[31:0];
  endfunction

endpackage

`default_nettype wire

[rtl/ftc_stream_ifs.sv]
// Valid/ready channel interfaces: packet header requests in, counter results out.
// Uses no package.
`default_nettype none

interface ftc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] l2_type;
  logic [7:0]  ip_protocol;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [15:0] src_l4;
  logic [15:0] dst_l4;
  logic [15:0] frame_length;

  modport source (
    output valid, l2_type, ip_protocol, src_addr, dst_addr, src_l4, dst_l4,
           frame_length,
    input  ready
  );
  modport sink (
    input  valid, l2_type, ip_protocol, src_addr, dst_addr, src_l4, dst_l4,
           frame_length,
    output ready
  );
endinterface

interface ftc_out_if;
  logic        valid;
  logic        ready;
  logic        flow_added;
  logic        table_full;
  logic [31:0] flows_total;
  logic [31:0] flows_tcp;
  logic [31:0] flows_udp;
  logic [31:0] packets_total;
  logic [31:0] packets_tcp;
  logic [31:0] packets_udp;
  logic [31:0] bytes_tcp;
  logic [31:0] bytes_udp;

  modport source (
    output valid, flow_added, table_full, flows_total, flows_tcp, flows_udp,
           packets_total, packets_tcp, packets_udp, bytes_tcp, bytes_udp,
    input  ready
  );
  modport sink (
    input  valid, flow_added, table_full, flows_total, flows_tcp, flows_udp,
           packets_total, packets_tcp, packets_udp, bytes_tcp, bytes_udp,
    output ready
  );
endinterface

`default_nettype wire

[rtl/flow_table_traffic_counter_top.sv]
// Top level of the flow table traffic counter: controller plus a chain of
// FLOW_ENTRIES table cells. Depends on ftc_pkg, ftc_stream_ifs, ftc_cell, ftc_ctrl.
//
//  channel   dir  handshake           carries
//  in_chan   in   valid/ready         one parsed packet header request
//  out_chan  out  valid/ready         flow flags and all eight counters
//
// A TCP/UDP request with IPv4/IPv6 ether type walks a token through the cell
// chain, one cell per cycle, before the next request is accepted. Any other
// request skips the lookup. The chain length sets the lookup time.
// Reset (rst_n low, synchronous) clears counters, the fill count and all valid
// state; table contents need no clearing. in_chan is taken whenever the
// controller is idle, even while a result waits; a stalled result holds in
// the output register.
`default_nettype none

module flow_table_traffic_counter_top #(
  parameter int unsigned FLOW_ENTRIES = ftc_pkg::FLOW_ENTRIES_DEF
) (
  input  wire       clk,
  input  wire       rst_n,
  ftc_in_if.sink    in_chan,
  ftc_out_if.source out_chan
);
  import ftc_pkg::*;

  localparam int unsigned FILL_W = $clog2(FLOW_ENTRIES + 1);

  ftc_key_t            key;
  ftc_link_t           link [0:FLOW_ENTRIES];
  logic                wr_en;
  logic [FILL_W - 1:0] fill;

  ftc_ctrl #(
    .FLOW_ENTRIES(FLOW_ENTRIES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .key        (key),
    .chain_head (link[0]),
    .chain_tail (link[FLOW_ENTRIES]),
    .wr_en      (wr_en),
    .fill       (fill)
  );

  // Cell chain
  for (genvar i = 0; i < FLOW_ENTRIES; i++) begin : g_cell
    ftc_cell #(
      .FLOW_ENTRIES(FLOW_ENTRIES),
      .CELL_IDX    (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .key      (key),
      .wr_en    (wr_en),
      .fill     (fill),
      .link_in  (link[i]),
      .link_out (link[i + 1])
    );
  end

endmodule

`default_nettype wire

[rtl/ftc_cell.sv]
// One flow table cell: holds one five-tuple entry, compares it with the
// broadcast key as the lookup token passes, and forwards the token. Uses ftc_pkg.
`default_nettype none

module ftc_cell #(
  parameter int unsigned FLOW_ENTRIES = ftc_pkg::FLOW_ENTRIES_DEF,
  parameter int unsigned CELL_IDX     = 0
) (
  input  wire                                       clk,
  input  wire                                       rst_n,
  input  wire ftc_pkg::ftc_key_t                    key,
  input  wire                                       wr_en,
  input  wire [$clog2(FLOW_ENTRIES + 1) - 1:0]      fill,
  input  wire ftc_pkg::ftc_link_t                   link_in,
  output ftc_pkg::ftc_link_t                        link_out
);
  import ftc_pkg::*;

  localparam int unsigned FILL_W = $clog2(FLOW_ENTRIES + 1);

  ftc_key_t  entry_r;
  ftc_link_t link_r;
  logic      occupied;
  logic      match;

  // Entries fill from the bottom and are never freed
  assign occupied = (fill > FILL_W'(CELL_IDX));
  assign match    = occupied && (entry_r == key);

  // Entry store: written once, when this cell is the lowest free one
  always_ff @(posedge clk) begin
    if (wr_en && (fill == FILL_W'(CELL_IDX))) begin
      entry_r <= key;
    end
  end

  // Token stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r <= '0;
    end else begin
      link_r.tok <= link_in.tok;
      link_r.hit <= link_in.tok & (link_in.hit | match);
    end
  end

  assign link_out = link_r;

endmodule

`default_nettype wire

[rtl/ftc_ctrl.sv]
// Controller: takes header requests, updates packet/byte/flow counters, launches
// the lookup token into the cell chain and registers results. Uses ftc_pkg and
// the channel interfaces.
`default_nettype none

module ftc_ctrl #(
  parameter int unsigned FLOW_ENTRIES = ftc_pkg::FLOW_ENTRIES_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  ftc_in_if.sink                               in_chan,
  ftc_out_if.source                            out_chan,
  output ftc_pkg::ftc_key_t                    key,
  output ftc_pkg::ftc_link_t                   chain_head,
  input  wire ftc_pkg::ftc_link_t              chain_tail,
  output logic                                 wr_en,
  output logic [$clog2(FLOW_ENTRIES + 1) - 1:0] fill
);
  import ftc_pkg::*;

  localparam int unsigned FILL_W = $clog2(FLOW_ENTRIES + 1);

  ftc_state_t          state_r, state_nxt;
  ftc_counts_t         cnt_r, cnt_nxt;
  ftc_counts_t         res_r;
  ftc_key_t            key_r, key_nxt;
  logic [FILL_W - 1:0] fill_r, fill_nxt;
  logic                tcp_r, tcp_nxt;
  logic                launch_r, launch_nxt;
  logic                made_r, made_nxt;
  logic                full_r, full_nxt;
  logic                out_valid_r;
  logic                flow_added_r, table_full_r;
  logic                load;
  logic                is_tcp, is_udp, ip_ok;

  // Header decode
  assign is_tcp = (in_chan.ip_protocol == PROTO_TCP);
  assign is_udp = (in_chan.ip_protocol == PROTO_UDP);
  assign ip_ok  = (in_chan.l2_type == L2_TYPE_IPV4) ||
                  (in_chan.l2_type == L2_TYPE_IPV6);

  // Next state, counters and strobes
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    key_nxt    = key_r;
    fill_nxt   = fill_r;
    tcp_nxt    = tcp_r;
    launch_nxt = 1'b0;
    made_nxt   = made_r;
    full_nxt   = full_r;
    wr_en      = 1'b0;
    load       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          key_nxt.src_addr = in_chan.src_addr;
          key_nxt.dst_addr = in_chan.dst_addr;
          key_nxt.src_l4   = in_chan.src_l4;
          key_nxt.dst_l4   = in_chan.dst_l4;
          key_nxt.protocol = in_chan.ip_protocol;
          tcp_nxt  = is_tcp;
          made_nxt = 1'b0;
          full_nxt = 1'b0;
          cnt_nxt.packets_total = sat_inc(cnt_r.packets_total);
          if (is_tcp) begin
            cnt_nxt.packets_tcp = sat_inc(cnt_r.packets_tcp);
          end
          if (is_udp) begin
            cnt_nxt.packets_udp = sat_inc(cnt_r.packets_udp);
          end
          if ((is_tcp || is_udp) && ip_ok) begin
            if (is_tcp) begin
              cnt_nxt.bytes_tcp = sat_add(cnt_r.bytes_tcp, in_chan.frame_length);
            end else begin
              cnt_nxt.bytes_udp = sat_add(cnt_r.bytes_udp, in_chan.frame_length);
            end
            launch_nxt = 1'b1;
            state_nxt  = ST_WALK;
          end else begin
            state_nxt = ST_PEND;
          end
        end
      end
      ST_WALK: begin
        // token has left the last cell: hit is final
        if (chain_tail.tok) begin
          if (!chain_tail.hit) begin
            if (fill_r == FILL_W'(FLOW_ENTRIES)) begin
              full_nxt = 1'b1;
            end else begin
              wr_en    = 1'b1;
              fill_nxt = fill_r + FILL_W'(1);
              made_nxt = 1'b1;
              cnt_nxt.flows_total = sat_inc(cnt_r.flows_total);
              if (tcp_r) begin
                cnt_nxt.flows_tcp = sat_inc(cnt_r.flows_tcp);
              end else begin
                cnt_nxt.flows_udp = sat_inc(cnt_r.flows_udp);
              end
            end
          end
          state_nxt = ST_PEND;
        end
      end
      ST_PEND: begin
        if (!out_valid_r || out_chan.ready) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      fill_r      <= '0;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      fill_r   <= fill_nxt;
      launch_r <= launch_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request payload and result registers
  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    tcp_r  <= tcp_nxt;
    made_r <= made_nxt;
    full_r <= full_nxt;
    if (load) begin
      res_r        <= cnt_r;
      flow_added_r <= made_r;
      table_full_r <= full_r;
    end
  end

  // Chain drive
  assign key             = key_r;
  assign chain_head.tok  = launch_r;
  assign chain_head.hit  = 1'b0;
  assign fill            = fill_r;

  // Channel drive
  assign in_chan.ready          = (state_r == ST_IDLE);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.flow_added    = flow_added_r;
  assign out_chan.table_full    = table_full_r;
  assign out_chan.flows_total   = res_r.flows_total;
  assign out_chan.flows_tcp     = res_r.flows_tcp;
  assign out_chan.flows_udp     = res_r.flows_udp;
  assign out_chan.packets_total = res_r.packets_total;
  assign out_chan.packets_tcp   = res_r.packets_tcp;
  assign out_chan.packets_udp   = res_r.packets_udp;
  assign out_chan.bytes_tcp     = res_r.bytes_tcp;
  assign out_chan.bytes_udp     = res_r.bytes_udp;

endmodule

`default_nettype wire

[rtl/ftc_checker.sv]
// Port-level checks for flow_table_traffic_counter_top, bound to the top level.
// Depends on the top level's channel interfaces.
`default_nettype none

module ftc_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire        flow_added,
  input wire        table_full,
  input wire [31:0] flows_total,
  input wire [31:0] flows_tcp,
  input wire [31:0] packets_total,
  input wire [31:0] packets_tcp
);

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(flows_total) &&
                                $stable(packets_total))
    else $error("stalled result changed");

  // One request at a time
  a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // A new flow and a full table never together; a new flow is counted
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(flow_added && table_full) && (!flow_added || flows_total != 32'd0))
    else $error("inconsistent flow flags");

  // Every flow was created by a packet of its kind (checked in total and for TCP)
  a_flows_le_pkts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (flows_total <= packets_total) && (flows_tcp <= packets_tcp))
    else $error("flow count exceeds packet count");

endmodule

bind flow_table_traffic_counter_top ftc_checker u_ftc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .flow_added    (out_chan.flow_added),
  .table_full    (out_chan.table_full),
  .flows_total   (out_chan.flows_total),
  .flows_tcp     (out_chan.flows_tcp),
  .packets_total (out_chan.packets_total),
  .packets_tcp   (out_chan.packets_tcp)
);

`default_nettype wire
